### hw/rtl/bdph_pkg.sv
package bdph_pkg;

    localparam int unsigned NUM_BUTTONS_DEF = 3;
    localparam int unsigned IDX_W           = 5;
    localparam int unsigned TIMER_W         = 16;
    localparam int unsigned APB_ADDR_W      = 3;
    localparam int unsigned APB_DATA_W      = 32;

    localparam logic [TIMER_W-1:0] HOLD_THR_RESET = 16'd300;
    localparam logic [TIMER_W-1:0] TIMER_START    = 16'd2;
    localparam logic [TIMER_W-1:0] TIMER_MAX      = 16'hFFFF;

    localparam logic [0:0] REG_HOLD_THRESHOLD = 1'b0;

    localparam logic [2:0] HIST_RELEASED = 3'b000;
    localparam logic [2:0] HIST_PRESSED  = 3'b111;

    typedef struct packed {
        logic [2:0]         hist;
        logic               stable;
        logic [TIMER_W-1:0] timer;
        logic               press;
        logic               hold;
    } btn_state_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] index;
        logic             sample;
    } bdph_req_t;

    typedef struct packed {
        logic stable;
        logic hold;
        logic press;
    } bdph_flags_t;

    function automatic btn_state_t bdph_update(
        input btn_state_t         cur,
        input logic               sample,
        input logic [TIMER_W-1:0] thr
    );
        btn_state_t         nxt;
        logic [2:0]         h;
        logic [TIMER_W-1:0] t;
        h        = {cur.hist[1:0], sample};
        nxt      = cur;
        nxt.hist = h;
        t        = cur.timer;
        if (h == HIST_RELEASED || h == HIST_PRESSED)
        begin
            unique case ({cur.stable, h[0]})
                2'b01:
                begin
                    nxt.stable = 1'b1;
                    nxt.timer  = TIMER_START;
                end
                2'b10:
                begin
                    nxt.stable = 1'b0;
                    if (cur.timer < thr)
                    begin
                        nxt.press = 1'b1;
                    end
                    else
                    begin
                        nxt.hold = 1'b0;
                    end
                    nxt.timer = '0;
                end
                2'b11:
                begin
                    if (cur.timer != TIMER_MAX)
                    begin
                        t = cur.timer + TIMER_W'(1);
                    end
                    nxt.timer = t;
                    if (t >= thr)
                    begin
                        nxt.hold = 1'b1;
                    end
                end
                default:
                begin
                    nxt.timer = '0;
                    nxt.hold  = 1'b0;
                    nxt.press = 1'b0;
                end
            endcase
        end
        return nxt;
    endfunction

endpackage

### hw/rtl/bdph_cfg.sv
module bdph_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bdph_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bdph_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bdph_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output logic [bdph_pkg::TIMER_W-1:0]         hold_threshold
);
    import bdph_pkg::*;

    logic [TIMER_W-1:0] thr_reg;
    logic [TIMER_W-1:0] thr_next;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2:2] == REG_HOLD_THRESHOLD);
    assign wr_en   = psel && penable && pwrite && pready && reg_sel;

    always_comb
    begin
        thr_next = thr_reg;
        if (wr_en)
        begin
            thr_next = pwdata[TIMER_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= HOLD_THR_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign prdata         = reg_sel ? APB_DATA_W'(thr_reg) : '0;
    assign hold_threshold = thr_reg;

endmodule

### hw/rtl/bdph_core.sv
module bdph_core #(
    parameter int unsigned NUM_BUTTONS = bdph_pkg::NUM_BUTTONS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bdph_pkg::bdph_req_t           req,
    input  logic [bdph_pkg::TIMER_W-1:0]  thr,
    output bdph_pkg::bdph_flags_t         flags
);
    import bdph_pkg::*;

    localparam int unsigned BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    btn_state_t state_reg [NUM_BUTTONS];
    btn_state_t cur;
    btn_state_t upd;
    logic       in_range;

    assign in_range = ({1'b0, req.index} < (IDX_W+1)'(NUM_BUTTONS));

    always_comb
    begin
        cur = '0;
        if (in_range)
        begin
            cur = state_reg[req.index[BW-1:0]];
        end
        upd = bdph_update(cur, req.sample, thr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else if (req.en && in_range)
        begin
            state_reg[req.index[BW-1:0]] <= upd;
        end
    end

    always_comb
    begin
        flags = '0;
        if (in_range)
        begin
            flags.press  = upd.press;
            flags.hold   = upd.hold;
            flags.stable = upd.stable;
        end
    end

endmodule

### hw/rtl/button_debounce_press_hold_unit.sv
// Channel     Dir  tdata bits (low first)                      Handshake
// s_axis      in   [4:0] button_index, [5] sample_pressed      tvalid/tready
// m_axis      out  [0] press_flag, [1] hold_flag,
//                  [2] stable_pressed                          tvalid/tready
// apb         in   reg 0 at 0x0: hold_threshold[15:0]          psel/penable
//
// One transfer per cycle sustained unless m_axis stalls; input reg, then result reg.
// The per-button state update and the result register share one stage, so the
// same button may arrive on consecutive cycles.
// Reset clears all button state and sets hold_threshold to 300.
// A stalled result holds both stages; s_axis_tready drops only when both are full.
module button_debounce_press_hold_unit #(
    parameter int unsigned NUM_BUTTONS = bdph_pkg::NUM_BUTTONS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // button_index, sample_pressed
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata,  // press, hold, stable_pressed
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bdph_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bdph_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bdph_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import bdph_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [IDX_W-1:0]   in_idx_reg;
    logic               in_sample_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    bdph_flags_t        out_flags_reg;
    bdph_flags_t        core_flags;
    bdph_req_t          req;
    logic [TIMER_W-1:0] thr;
    logic               advance;
    logic               in_xfer;

    bdph_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .hold_threshold (thr)
    );

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign req.en     = in_valid_reg && advance;
    assign req.index  = in_idx_reg;
    assign req.sample = in_sample_reg;

    bdph_core #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .thr   (thr),
        .flags (core_flags)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
        end
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_idx_reg    <= s_axis_tdata[IDX_W-1:0];
            in_sample_reg <= s_axis_tdata[IDX_W];
        end
        if (req.en)
        begin
            out_flags_reg <= core_flags;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_flags_reg.stable, out_flags_reg.hold,
                            out_flags_reg.press};

endmodule

### hw/rtl/bdph_checker.sv
module bdph_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [7:0]                         s_axis_tdata,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [7:0]                         m_axis_tdata,
    input logic                               psel,
    input logic                               penable,
    input logic                               pwrite,
    input logic [bdph_pkg::APB_ADDR_W-1:0]    paddr,
    input logic [bdph_pkg::APB_DATA_W-1:0]    pwdata,
    input logic [bdph_pkg::APB_DATA_W-1:0]    prdata,
    input logic                               pready
);
    import bdph_pkg::*;

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:3] == 5'b0)
        else $error("result padding not zero");

    a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output side can drain");

    a_prdata_upper: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[APB_DATA_W-1:TIMER_W] == '0)
        else $error("read data upper bits not zero");

endmodule

bind button_debounce_press_hold_unit bdph_checker u_bdph_checker (.*);

### bench/button_debounce_press_hold_check.sv
module button_debounce_press_hold_check #(
    parameter int unsigned NUM_BUTTONS = bdph_pkg::NUM_BUTTONS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // button_index, sample_pressed
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [7:0]                      m_axis_tdata,  // press, hold, stable_pressed
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bdph_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bdph_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [bdph_pkg::APB_DATA_W-1:0] prdata,
    input  logic                            pready,
    output int unsigned                     mismatch_count,
    output int unsigned                     pending_results,
    output int unsigned                     results_checked,
    output int unsigned                     press_seen,
    output int unsigned                     hold_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import bdph_pkg::*;

    logic [TIMER_W-1:0] hold_limit;
    logic [2:0]         sample_hist [NUM_BUTTONS];
    logic               debounced   [NUM_BUTTONS];
    logic [TIMER_W-1:0] hold_ticks  [NUM_BUTTONS];
    logic               short_mark  [NUM_BUTTONS];
    logic               long_mark   [NUM_BUTTONS];
    bdph_flags_t        expected_flags [$];

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatch_count < 25)
        begin
            $display("%0t ns: mismatch on %s, expected %0h, got %0h", $time, what, want, got);
        end
        mismatch_count++;
    endtask

    function automatic bdph_flags_t debounce_tick(input logic [IDX_W-1:0] idx, input logic lvl);
        bdph_flags_t flags;
        logic [2:0]  h;
        int unsigned b;
        flags = '0;
        if (idx < NUM_BUTTONS)
        begin
            b = idx;
            h = {sample_hist[b][1:0], lvl};
            sample_hist[b] = h;
            if (h == HIST_RELEASED || h == HIST_PRESSED)
            begin
                if (!debounced[b] && lvl)
                begin
                    debounced[b]  = 1'b1;
                    hold_ticks[b] = TIMER_START;
                end
                else if (debounced[b] && !lvl)
                begin
                    debounced[b] = 1'b0;
                    if (hold_ticks[b] < hold_limit)
                    begin
                        short_mark[b] = 1'b1;
                    end
                    else
                    begin
                        long_mark[b] = 1'b0;
                    end
                    hold_ticks[b] = '0;
                end
                else if (debounced[b] && lvl)
                begin
                    if (hold_ticks[b] != TIMER_MAX)
                    begin
                        hold_ticks[b] = hold_ticks[b] + 1'b1;
                    end
                    if (hold_ticks[b] >= hold_limit)
                    begin
                        long_mark[b] = 1'b1;
                    end
                end
                else
                begin
                    hold_ticks[b] = '0;
                    long_mark[b]  = 1'b0;
                    short_mark[b] = 1'b0;
                end
            end
            flags.press  = short_mark[b];
            flags.hold   = long_mark[b];
            flags.stable = debounced[b];
        end
        return flags;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bdph_flags_t want;
        if (!rst_n)
        begin
            hold_limit = HOLD_THR_RESET;
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                sample_hist[b] = HIST_RELEASED;
                debounced[b]   = 1'b0;
                hold_ticks[b]  = '0;
                short_mark[b]  = 1'b0;
                long_mark[b]   = 1'b0;
            end
            expected_flags.delete();
            mismatch_count  = 0;
            pending_results = 0;
            results_checked = 0;
            press_seen      = 0;
            hold_seen       = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_HOLD_THRESHOLD)
            begin
                if (pwrite)
                begin
                    hold_limit = pwdata[TIMER_W-1:0];
                end
                else if (prdata !== {{(APB_DATA_W-TIMER_W){1'b0}}, hold_limit})
                begin
                    report_mismatch("hold_threshold read", hold_limit, prdata);
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_flags.size() == 0)
                begin
                    report_mismatch("result with nothing outstanding", 0, m_axis_tdata);
                end
                else
                begin
                    want = expected_flags.pop_front();
                    if (m_axis_tdata[0] !== want.press)
                    begin
                        report_mismatch("press_flag", want.press, m_axis_tdata[0]);
                    end
                    if (m_axis_tdata[1] !== want.hold)
                    begin
                        report_mismatch("hold_flag", want.hold, m_axis_tdata[1]);
                    end
                    if (m_axis_tdata[2] !== want.stable)
                    begin
                        report_mismatch("stable_pressed", want.stable, m_axis_tdata[2]);
                    end
                    results_checked++;
                    if (want.press)
                    begin
                        press_seen++;
                    end
                    if (want.hold)
                    begin
                        hold_seen++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_flags.push_back(debounce_tick(s_axis_tdata[IDX_W-1:0],
                                                       s_axis_tdata[IDX_W]));
            end
            pending_results = expected_flags.size();
        end
    end

endmodule

### bench/button_debounce_press_hold_unit_test.sv
module button_debounce_press_hold_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bdph_pkg::*;

    localparam int unsigned BUTTONS     = NUM_BUTTONS_DEF;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned LONG_RUN_TICKS = 40;
    localparam logic [0:0]  REG_UNUSED  = 1'b1;
    localparam logic [APB_ADDR_W-1:0] THR_ADDR    = {REG_HOLD_THRESHOLD, 2'b00};
    localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = {REG_UNUSED, 2'b00};

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned mismatch_count;
    int unsigned pending_results;
    int unsigned results_checked;
    int unsigned press_seen;
    int unsigned hold_seen;

    int unsigned cycle_count;
    int unsigned sent_total;
    bit          steady;
    bit          send_burst;
    int unsigned run_left  [BUTTONS];
    logic        run_level [BUTTONS];

    button_debounce_press_hold_unit #(
        .NUM_BUTTONS (BUTTONS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    button_debounce_press_hold_check #(
        .NUM_BUTTONS (BUTTONS)
    ) i_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .press_seen      (press_seen),
        .hold_seen       (hold_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("button_debounce_press_hold_unit_test: errors");
        $finish;
    end

    // hold the result channel in random stalls, with quiet stretches between them
    initial
    begin
        int unsigned stall_left;
        int unsigned ticks;
        bit          sink_quiet;
        stall_left    = 0;
        ticks         = 0;
        sink_quiet    = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            ticks++;
            if (ticks % 150 == 0)
            begin
                sink_quiet = ($urandom_range(0, 3) == 0);
            end
            if (stall_left == 0 && !steady && !sink_quiet && $urandom_range(0, 99) < 30)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
            end
            m_axis_tready <= (stall_left == 0);
            if (stall_left > 0)
            begin
                stall_left--;
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady || send_burst)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic push_sample(input logic [IDX_W-1:0] idx, input logic lvl);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, lvl, idx};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        sent_total++;
        if (sent_total % 64 == 0)
        begin
            send_burst = ($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic push_run(input logic [IDX_W-1:0] idx, input logic lvl, input int unsigned n);
        repeat (n) push_sample(idx, lvl);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_threshold(input logic [TIMER_W-1:0] thr);
        settle();
        apb_access(1'b1, THR_ADDR, {16'($urandom()), thr});
        apb_access(1'b0, THR_ADDR, '0);
    endtask

    task automatic run_random(input logic [TIMER_W-1:0] thr, input int unsigned count);
        int unsigned      run_cap;
        int unsigned      b;
        logic [IDX_W-1:0] idx;
        logic             lvl;
        set_threshold(thr);
        run_cap = (thr > 60) ? 66 : thr + 6;
        for (int unsigned n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                idx = IDX_W'($urandom_range(BUTTONS, 31));
                lvl = 1'($urandom_range(0, 1));
            end
            else
            begin
                b = $urandom_range(0, BUTTONS - 1);
                if (run_left[b] == 0)
                begin
                    if ($urandom_range(0, 4) != 0)
                    begin
                        run_level[b] = ~run_level[b];
                    end
                    run_left[b] = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2)
                                                              : $urandom_range(3, run_cap);
                end
                run_left[b]--;
                idx = IDX_W'(b);
                lvl = run_level[b] ^ ($urandom_range(0, 99) < 4);
            end
            push_sample(idx, lvl);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        steady        = 1'b0;
        send_burst    = 1'b0;
        sent_total    = 0;
        for (int b = 0; b < BUTTONS; b++)
        begin
            run_left[b]  = 0;
            run_level[b] = 1'b0;
        end
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        apb_access(1'b0, THR_ADDR, '0);
        push_sample(5'd31, 1'b1);
        push_sample(IDX_W'(BUTTONS), 1'b0);
        push_run(5'd0, 1'b1, 3);
        push_run(5'd0, 1'b0, 3);
        push_sample(5'd0, 1'b0);
        push_sample(5'd1, 1'b1);
        push_sample(5'd1, 1'b0);
        push_run(5'd1, 1'b1, 3);

        set_threshold(16'd3);
        apb_access(1'b1, UNUSED_ADDR, 32'hFFFF_FFFF);
        apb_access(1'b0, THR_ADDR, '0);
        push_run(5'd1, 1'b1, 2);
        push_run(5'd1, 1'b0, 3);

        set_threshold(16'd0);
        push_run(5'd2, 1'b1, 4);
        push_run(5'd2, 1'b0, 3);
        push_sample(5'd2, 1'b0);

        // hold well short of the top threshold, back to back
        set_threshold(TIMER_MAX);
        steady = 1'b1;
        push_run(5'd0, 1'b1, LONG_RUN_TICKS);
        push_run(5'd0, 1'b0, 4);
        steady = 1'b0;

        run_random(16'd1, 340);
        run_random(16'($urandom_range(2, 6)), 340);
        run_random(16'($urandom_range(7, 25)), 340);
        run_random(16'd0, 340);
        run_random(16'($urandom_range(26, 60)), 340);

        settle();
        repeat (8) @(negedge clk);
        $display("covered %0d samples: thresholds 300, 3, 0, 65535 (with a %0d-tick hold)",
                 results_checked, LONG_RUN_TICKS);
        $display("plus five random settings; %0d results with press flag, %0d with hold flag",
                 press_seen, hold_seen);
        if (mismatch_count == 0)
        begin
            $display("button_debounce_press_hold_unit_test: clean");
        end
        else
        begin
            $display("button_debounce_press_hold_unit_test: errors");
        end
        $finish;
    end

endmodule
